// ===== rtl/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; imported by rtl/modular_exponentiation.sv and dv/tb_modular_exponentiation.sv.
package modexp_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH           = 32;
   localparam int CSR_INDEX_WIDTH       = 1;

   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd2958613181; // 89963 * 32887
   localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd257;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS      = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_EXPONENT = 1'b1;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] base;
      logic                   last_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] residue;
      logic                   last_out;
   } rsp_type;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation (square-and-multiply) with a bit-serial modular multiplier.
// Depends on rtl/modexp_pkg.sv for word types, register indexes and reset values.
//
// Usage:
//   req channel (valid/ready) carries one word: base and last_in.
//   rsp channel (valid/ready) returns one word: base^key_exponent mod modulus
//   and last_out, a copy of last_in.
//   csr port: csr_we with csr_index 0 (modulus) or 1 (key_exponent) writes
//   csr_wdata. Write only while no word is in flight.
// Operation, W = OPERAND_WIDTH:
//   One modular multiply steps through its W multiplier bits, one bit per cycle
//   (interleaved shift-add with a two-way conditional subtract).
//   A word first reduces the base, then runs one multiply or square at a time:
//   one square for each exponent bit below the top set bit
//   and one multiply for each set bit. Exponent zero or modulus zero go
//   straight to the result.
//   One word is processed at a time; req_ready is high when the engine is free.
// Reset: synchronous; loads the modulus and exponent reset values, returns to idle, drops rsp_valid.
// Stall: a finished result sits in the output register; the engine takes
//   the next word meanwhile and holds its own result until rsp is taken.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  modexp_pkg::req_type                     req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output modexp_pkg::rsp_type                     rsp_data,
   input  logic                                    csr_we,
   input  logic [modexp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0]      csr_wdata
);
   import modexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);
   localparam logic [W-1:0]     ONE      = {{(W-1){1'b0}}, 1'b1};

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [FIELD_WIDTH-1:0] modulus_ff, modulus_in;
   logic [FIELD_WIDTH-1:0] exponent_ff, exponent_in;
   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           m_ff, m_in;
   logic [W-1:0]           e_ff, e_in;
   logic [W-1:0]           base_ff, base_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           p_ff, p_in;
   logic [W-1:0]           mplier_ff, mplier_in;
   logic [W-1:0]           mcand_ff, mcand_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [W-1:0]   addend;
   logic [W+1:0]   sum;
   logic [W+1:0]   diff1;
   logic [W+1:0]   diff2;
   logic [W-1:0]   step_res;
   logic [W-1:0]   req_base;
   logic [W-1:0]   req_exp;
   logic           req_accept;
   logic           op_done;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign req_base   = req_data.base[W-1:0];
   assign req_exp    = exponent_ff[W-1:0];
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // one bit of the interleaved multiply: p = (2p + bit*mcand) mod m, sum < 3m
   always_comb begin
      addend   = mplier_ff[W-1] ? mcand_ff : '0;
      sum      = {1'b0, p_ff, 1'b0} + {2'b00, addend};
      diff1    = sum - {2'b00, m_ff};
      diff2    = sum - {1'b0, m_ff, 1'b0};
      if (!diff2[W+1]) begin
         step_res = diff2[W-1:0];
      end else if (!diff1[W+1]) begin
         step_res = diff1[W-1:0];
      end else begin
         step_res = sum[W-1:0];
      end
      op_done = (cnt_ff == CNT_LAST);
   end

   always_comb begin
      modulus_in   = modulus_ff;
      exponent_in  = exponent_ff;
      state_in     = state_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      mplier_in    = mplier_ff;
      mcand_in     = mcand_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:      modulus_in  = csr_wdata;
            CSR_KEY_EXPONENT: exponent_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               m_in      = modulus_ff[W-1:0];
               e_in      = req_exp;
               last_in   = req_data.last_in;
               // reduce the base as base * 1 mod m
               mplier_in = req_base;
               mcand_in  = ONE;
               p_in      = '0;
               cnt_in    = '0;
               if (req_exp == '0) begin
                  acc_in   = ONE;
                  state_in = ST_FIN;
               end else if (modulus_ff[W-1:0] == '0) begin
                  acc_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  acc_in   = ONE;
                  state_in = ST_RED;
               end
            end
         end
         ST_RED, ST_MUL, ST_SQR: begin
            p_in      = step_res;
            mplier_in = {mplier_ff[W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (op_done) begin
               p_in   = '0;
               cnt_in = '0;
               case (state_ff)
                  ST_RED: begin
                     base_in = step_res;
                     if (e_ff[0]) begin
                        mplier_in = acc_ff;
                        mcand_in  = step_res;
                        state_in  = ST_MUL;
                     end else begin
                        mplier_in = step_res;
                        mcand_in  = step_res;
                        state_in  = ST_SQR;
                     end
                  end
                  ST_MUL: begin
                     acc_in = step_res;
                     // no square needed once the top set bit is consumed
                     if (e_ff[W-1:1] == '0) begin
                        state_in = ST_FIN;
                     end else begin
                        mplier_in = base_ff;
                        mcand_in  = base_ff;
                        state_in  = ST_SQR;
                     end
                  end
                  default: begin
                     base_in = step_res;
                     e_in    = e_ff >> 1;
                     if (e_ff[1]) begin
                        mplier_in = acc_ff;
                        mcand_in  = step_res;
                        state_in  = ST_MUL;
                     end else begin
                        mplier_in = step_res;
                        mcand_in  = step_res;
                        state_in  = ST_SQR;
                     end
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.residue  = {{(FIELD_WIDTH-W){1'b0}}, acc_ff};
               rsp_data_in.last_out = last_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         exponent_ff  <= EXPONENT_RESET;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      e_ff        <= e_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      mplier_ff   <= mplier_in;
      mcand_ff    <= mcand_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // partial product stays reduced while the multiplier runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED || state_ff == ST_MUL || state_ff == ST_SQR) |-> (p_ff < m_ff))
      else $error("partial product not reduced");

   // finished residue is below the modulus unless a special case applied
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && e_ff != '0 && m_ff != '0) |-> (acc_ff < m_ff))
      else $error("residue not reduced");

   // zero exponent goes straight to the result with value one
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_exp == '0) |=> (state_ff == ST_FIN && acc_ff == ONE))
      else $error("zero exponent not short-cut");

endmodule

// ===== dv/tb_modular_exponentiation.sv =====
// Self-checking testbench for modular_exponentiation: base^exponent mod modulus words
// are predicted in the bench and compared field by field with the rsp channel.
// Depends on rtl/modexp_pkg.sv and rtl/modular_exponentiation.sv.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
   import modexp_pkg::*;

   localparam int OPW = OPERAND_WIDTH_DEFAULT;
   // upper bound for one worst-case word with margin, used for the tail wait
   localparam int WORD_CYCLES_MAX = 2 * OPW * OPW + 50;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_MODULUS;
   logic [FIELD_WIDTH-1:0]     csr_wdata = '0;

   // bench copy of the key registers
   logic [FIELD_WIDTH-1:0] key_modulus = MODULUS_RESET;
   logic [FIELD_WIDTH-1:0] key_exp = EXPONENT_RESET;

   rsp_type pending_residues[$];
   int      mismatch_count = 0;
   int      residues_checked = 0;
   int      key_settings = 1;
   bit      no_stall = 1'b0;

   modular_exponentiation #(.OPERAND_WIDTH(OPW)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

   // square-and-multiply on the bench's key copy, exponent scanned LSB first
   function automatic rsp_type power_mod(input req_type word);
      bit [63:0] mask;
      bit [63:0] b;
      bit [63:0] e;
      bit [63:0] m;
      bit [63:0] acc;
      rsp_type   r;
      mask = (64'd1 << OPW) - 64'd1;
      b = {32'd0, word.base} & mask;
      e = {32'd0, key_exp} & mask;
      m = {32'd0, key_modulus} & mask;
      acc = 64'd1;
      if (e != 0) begin
         if (m == 0) begin
            acc = 64'd0;
         end else begin
            b = b % m;
            while (e != 0) begin
               if (e[0]) acc = (acc * b) % m;
               b = (b * b) % m;
               e = e >> 1;
            end
         end
      end
      r.residue = acc[FIELD_WIDTH-1:0];
      r.last_out = word.last_in;
      return r;
   endfunction

   // receiver stalls about a quarter of the cycles, none during the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= no_stall ? 1'b1 : ($urandom_range(99) >= 26);
   end

   // values are stable at the falling edge, so a word seen here is taken at the next rise
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_residues.size() == 0) begin
            $display("%0t: unexpected word, got residue %h last %b",
                     $time, rsp_data.residue, rsp_data.last_out);
            mismatch_count++;
         end else begin
            want = pending_residues.pop_front();
            residues_checked++;
            if (rsp_data.residue !== want.residue) begin
               $display("%0t: residue mismatch, expected %h got %h",
                        $time, want.residue, rsp_data.residue);
               mismatch_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $display("%0t: last_out mismatch, expected %b got %b",
                        $time, want.last_out, rsp_data.last_out);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_base(input logic [FIELD_WIDTH-1:0] base, input logic last);
      int      gap;
      bit      took;
      req_type word;
      gap = 0;
      if (!no_stall && $urandom_range(99) < 26)
         gap = ($urandom_range(19) == 0) ? $urandom_range(100, 2500) : $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word.base = base;
      word.last_in = last;
      req_valid <= 1'b1;
      req_data <= word;
      do begin
         @(negedge clock);
         took = req_valid && req_ready;
         @(posedge clock);
      end while (!took);
      pending_residues.push_back(power_mod(word));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after its last write
   task automatic load_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                input logic [FIELD_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_MODULUS) key_modulus = value;
      else if (idx == CSR_KEY_EXPONENT) key_exp = value;
   endtask

   task automatic set_key(input logic [FIELD_WIDTH-1:0] m, input logic [FIELD_WIDTH-1:0] e);
      wait_drained();
      load_register(CSR_MODULUS, m);
      load_register(CSR_KEY_EXPONENT, e);
      csr_we <= 1'b0;
      key_settings++;
   endtask

   // reset key values, bases around the modulus and at the field limits
   task automatic test_reset_key();
      send_base(32'd0, 1'b0);
      send_base(32'd1, 1'b1);
      send_base(32'd2, 1'b0);
      send_base(MODULUS_RESET - 32'd1, 1'b0);
      send_base(MODULUS_RESET, 1'b0);
      send_base(MODULUS_RESET + 32'd1, 1'b1);
      send_base(32'hFFFF_FFFF, 1'b1);
   endtask

   // exponent zero gives 1 for any modulus, including 1 and 0
   task automatic test_exponent_zero();
      set_key(MODULUS_RESET, 32'd0);
      send_base(32'd0, 1'b0);
      send_base(32'hFFFF_FFFF, 1'b1);
      send_base(32'd12345, 1'b0);
      set_key(32'd1, 32'd0);
      send_base(32'd7, 1'b1);
      set_key(32'd0, 32'd0);
      send_base(32'hFFFF_FFFF, 1'b0);
   endtask

   // modulus one and modulus zero with a nonzero exponent both give 0
   task automatic test_degenerate_modulus();
      set_key(32'd1, 32'hFFFF_FFFF);
      send_base(32'hFFFF_FFFF, 1'b1);
      send_base(32'd0, 1'b0);
      set_key(32'd0, 32'd5);
      send_base(32'd9, 1'b1);
      send_base(32'd0, 1'b0);
   endtask

   task automatic test_operand_extremes();
      set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_base(32'hFFFF_FFFF, 1'b0);
      send_base(32'hFFFF_FFFE, 1'b1);
      set_key(32'hFFFF_FFFF, 32'd1);
      send_base(32'hFFFF_FFFF, 1'b0);
      send_base(32'hFFFF_FFFE, 1'b0);
      send_base(32'h8000_0000, 1'b1);
      set_key(32'd2, 32'd3);
      send_base(32'hFFFF_FFFF, 1'b1);
   endtask

   // several keys; most exponents short so the run stays short, two phases full width
   task automatic test_random_keys();
      logic [FIELD_WIDTH-1:0] m;
      logic [FIELD_WIDTH-1:0] e;
      logic [FIELD_WIDTH-1:0] b;
      int                     pick;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: m = $urandom | 32'h8000_0001;
            1: m = $urandom_range(1, 255);
            2: m = 32'd1 << $urandom_range(1, 31);
            default: m = $urandom;
         endcase
         case (phase % 5)
            0: e = $urandom_range(2, 31);
            1: e = 32'd65537;
            2: e = ($urandom & 32'h0000_FFFF) | 32'd1;
            3: e = $urandom | 32'h8000_0000;
            default: e = $urandom_range(1, 1023);
         endcase
         set_key(m, e);
         no_stall = (phase == 6);
         for (int i = 0; i < 73; i++) begin
            // hold off until every word of this key sent so far is back
            if (i == 36 && phase % 3 == 1) wait_drained();
            pick = $urandom_range(99);
            if (pick < 55) b = $urandom;
            else if (pick < 70) b = $urandom_range(0, 255);
            else if (pick < 82) b = m - $urandom_range(0, 2);
            else if (pick < 92) b = m + $urandom_range(0, 3);
            else b = pick[0] ? 32'hFFFF_FFFF : 32'h0;
            send_base(b, $urandom_range(7) == 0);
         end
      end
      no_stall = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_exponent_zero();
      test_degenerate_modulus();
      test_operand_extremes();
      test_random_keys();
      wait_drained();
      repeat (WORD_CYCLES_MAX) @(posedge clock);
      $display("Checked %0d words over %0d key settings: reset key, zero exponent,",
               residues_checked, key_settings);
      $display("modulus 0/1/all-ones, random keys and bases, stalls on both sides.");
      if (mismatch_count == 0 && pending_residues.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
